[hw/rtl/kab_pkg.sv]
// ----------------------------------------------------------------------------
// kab_pkg
// Shared widths, field offsets, command codes and status bundle for the
// k-th ancestor binary-lifting unit.
// ----------------------------------------------------------------------------
package kab_pkg;

  // Fixed field widths of the stream and configuration ports
  localparam int NODE_W = 10;
  localparam int PAR_W  = 11;
  localparam int DIST_W = 10;
  localparam int CNT_W  = 11;
  localparam int ANC_W  = 11;

  // Input tdata layout: node_index, parent_of_node, distance
  localparam int NODE_LSB    = 0;
  localparam int PAR_LSB     = NODE_LSB + NODE_W;
  localparam int DIST_LSB    = PAR_LSB + PAR_W;
  localparam int IN_FIELDS_W = DIST_LSB + DIST_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ANC_W + 7) / 8) * 8;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_LEVELS    = 11;

  // Datapath commands issued by the controller
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_TAKE,       // latch input item, clear walk counters
    CMD_LOAD,       // write level-0 parent entry
    CMD_FIX_RD,     // read level-0 entry of node j
    CMD_FIX_WR,     // write back range-checked level-0 entry, advance j
    CMD_BLD_RD1,    // read entry (lvl-1, j)
    CMD_BLD_RD2,    // read entry (lvl-1, mid)
    CMD_BLD_SKIP,   // write none to (lvl, j), advance
    CMD_BLD_WR,     // write checked read data to (lvl, j), advance
    CMD_SET_BUILT,
    CMD_Q_NONE,     // result is none
    CMD_Q_NEXT,     // skip clear bit of k
    CMD_Q_RD,       // read entry (lvl, cur)
    CMD_Q_STEP,     // take read data as new current node
    CMD_Q_END,      // result is current node
    CMD_Q_PUSH      // move result into output register
  } kab_cmd_e;

  typedef struct packed {
    logic in_is_query;  // operation of the item on the input port
    logic last_load;    // latched last flag
    logic q_ok;         // query is answerable
    logic bit_set;      // bit lvl of k is set
    logic lvl_last;     // level counter at LEVELS-1
    logic j_last;       // node counter at count-1
    logic count_zero;   // no node in use
    logic rd_in_use;    // read data is an in-use node
    logic out_free;     // output register can take a result
  } kab_stat_t;

endpackage

[hw/rtl/kab_mem.sv]
// ----------------------------------------------------------------------------
// kab_mem
// Single-write, single-read table memory with registered read data.
// ----------------------------------------------------------------------------
module kab_mem #(
  parameter int EW    = 11,
  parameter int AW    = 14,
  parameter int DEPTH = 11264
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [EW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [EW-1:0] rdata_o
);

  logic [EW-1:0] mem_q [DEPTH];
  logic [EW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/kab_dp.sv]
// ----------------------------------------------------------------------------
// kab_dp
// Datapath: item registers, node and level counters, lifting table access,
// range checks, result and output registers, node_count register.
// ----------------------------------------------------------------------------
module kab_dp import kab_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int LEVELS    = DEF_LEVELS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kab_cmd_e               cmd_i,
  output kab_stat_t              stat_o,
  input  logic                   in_op_i,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  input  logic                   in_last_i,
  input  logic                   cfg_we_i,
  input  logic [CNT_W-1:0]       cfg_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int EW    = NW + 1;
  localparam int AW    = LW + NW;
  localparam int DEPTH = LEVELS * (2 ** NW);
  localparam int XW    = (NW + 1 > CNT_W) ? NW + 1 : CNT_W;
  localparam int KW    = (LEVELS > DIST_W) ? LEVELS : DIST_W;
  localparam logic [EW-1:0] ENTRY_NONE = {1'b1, {NW{1'b0}}};

  logic [CNT_W-1:0]  node_count_q;
  logic              built_q;
  logic [NODE_W-1:0] node_q;
  logic [PAR_W-1:0]  par_q;
  logic [DIST_W-1:0] dist_q;
  logic              last_q;
  logic [NW-1:0]     j_q;
  logic [LW-1:0]     lvl_q;
  logic [NW-1:0]     cur_q;
  logic [EW-1:0]     res_q;
  logic              out_valid_q;
  logic [ANC_W-1:0]  out_anc_q;

  logic [XW-1:0]     cnt_eff;
  logic [XW-1:0]     node_x;
  logic [XW-1:0]     dist_x;
  logic [KW-1:0]     dist_k;
  logic              par_in_use;
  logic [EW-1:0]     rd_data;
  logic              rd_in_use;
  logic [EW-1:0]     rd_checked;
  logic [LW-1:0]     lvl_prev;
  logic              j_last;
  logic              advance;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [EW-1:0]     mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  assign cnt_eff = (XW'(node_count_q) > XW'(MAX_NODES)) ? XW'(MAX_NODES)
                                                        : XW'(node_count_q);
  assign node_x  = XW'(node_q);
  assign dist_x  = XW'(dist_q);
  assign dist_k  = KW'(dist_q);
  assign par_in_use = !par_q[PAR_W-1] && (XW'(par_q[PAR_W-2:0]) < cnt_eff);
  assign rd_in_use  = !rd_data[EW-1] && (XW'(rd_data[NW-1:0]) < cnt_eff);
  assign rd_checked = rd_in_use ? rd_data : ENTRY_NONE;
  assign lvl_prev   = lvl_q - LW'(1);
  assign j_last     = (XW'(j_q) == cnt_eff - XW'(1));
  assign advance    = (cmd_i == CMD_FIX_WR) || (cmd_i == CMD_BLD_SKIP) ||
                      (cmd_i == CMD_BLD_WR);

  // Table access: address is {level, node}
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {lvl_q, j_q};
    mem_wdata = rd_checked;
    mem_re    = 1'b0;
    mem_raddr = {lvl_q, cur_q};
    unique case (cmd_i)
      CMD_LOAD: begin
        mem_we    = (node_x < cnt_eff);
        mem_waddr = {LW'(0), NW'(node_q)};
        mem_wdata = par_in_use ? {1'b0, NW'(par_q[PAR_W-2:0])} : ENTRY_NONE;
      end
      CMD_FIX_RD: begin
        mem_re    = 1'b1;
        mem_raddr = {LW'(0), j_q};
      end
      CMD_FIX_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {LW'(0), j_q};
      end
      CMD_BLD_RD1: begin
        mem_re    = 1'b1;
        mem_raddr = {lvl_prev, j_q};
      end
      CMD_BLD_RD2: begin
        mem_re    = 1'b1;
        mem_raddr = {lvl_prev, rd_data[NW-1:0]};
      end
      CMD_BLD_SKIP: begin
        mem_we    = 1'b1;
        mem_wdata = ENTRY_NONE;
      end
      CMD_BLD_WR: begin
        mem_we    = 1'b1;
      end
      CMD_Q_RD: begin
        mem_re    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  kab_mem #(
    .EW    (EW),
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd_data)
  );

  // Item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_TAKE) begin
      node_q <= in_data_i[NODE_LSB +: NODE_W];
      par_q  <= in_data_i[PAR_LSB +: PAR_W];
      dist_q <= in_data_i[DIST_LSB +: DIST_W];
      last_q <= in_last_i;
    end
  end

  // Counters and walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q   <= '0;
      lvl_q <= '0;
      cur_q <= '0;
      res_q <= ENTRY_NONE;
    end else begin
      if (cmd_i == CMD_TAKE) begin
        j_q   <= '0;
        lvl_q <= '0;
        cur_q <= NW'(in_data_i[NODE_LSB +: NODE_W]);
      end else if (advance) begin
        // finish a row of nodes, then move up one level
        if (j_last) begin
          j_q   <= '0;
          lvl_q <= lvl_q + LW'(1);
        end else begin
          j_q <= j_q + NW'(1);
        end
      end else if (cmd_i == CMD_Q_NEXT) begin
        lvl_q <= lvl_q + LW'(1);
      end else if (cmd_i == CMD_Q_STEP) begin
        lvl_q <= lvl_q + LW'(1);
        cur_q <= rd_data[NW-1:0];
        res_q <= {1'b0, rd_data[NW-1:0]};
      end
      if (cmd_i == CMD_Q_NONE) begin
        res_q <= ENTRY_NONE;
      end else if (cmd_i == CMD_Q_END) begin
        res_q <= {1'b0, cur_q};
      end
    end
  end

  // Configuration and built flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CNT_W'(1);
      built_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_data_i;
        built_q      <= 1'b0;
      end else if (cmd_i == CMD_SET_BUILT) begin
        built_q <= 1'b1;
      end else if (cmd_i == CMD_LOAD && !last_q) begin
        built_q <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i == CMD_Q_PUSH) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_Q_PUSH) begin
      out_anc_q <= res_q[EW-1] ? {ANC_W{1'b1}} : ANC_W'(res_q[NW-1:0]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = OUT_TDATA_W'(out_anc_q);

  always_comb begin
    stat_o.in_is_query = in_op_i;
    stat_o.last_load   = last_q;
    stat_o.q_ok        = built_q && (node_x < cnt_eff) && (dist_x < cnt_eff) &&
                         ((dist_k >> LEVELS) == '0);
    stat_o.bit_set     = dist_k[lvl_q];
    stat_o.lvl_last    = (lvl_q == LW'(LEVELS - 1));
    stat_o.j_last      = j_last;
    stat_o.count_zero  = (cnt_eff == '0);
    stat_o.rd_in_use   = rd_in_use;
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_Q_PUSH) |-> (!out_valid_q || out_ready_i))
    else $error("result pushed over an untaken result");

  a_wr_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (mem_waddr[AW-1:NW] < LW'(LEVELS - 1) ||
                mem_waddr[AW-1:NW] == LW'(LEVELS - 1)))
    else $error("table write beyond last level");

  a_built_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(built_q) |-> $past(cmd_i == CMD_SET_BUILT))
    else $error("table marked built without a build");

  a_no_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("table read and written in one cycle");

endmodule

[hw/rtl/kab_ctrl.sv]
// ----------------------------------------------------------------------------
// kab_ctrl
// Controller: sequences loads, the table build and the query walk.
// ----------------------------------------------------------------------------
module kab_ctrl import kab_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  kab_stat_t stat_i,
  output kab_cmd_e  cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LOAD    = 4'd1;
  localparam logic [3:0] S_FIX_RD  = 4'd2;
  localparam logic [3:0] S_FIX_WR  = 4'd3;
  localparam logic [3:0] S_BLD_RD1 = 4'd4;
  localparam logic [3:0] S_BLD_CHK = 4'd5;
  localparam logic [3:0] S_BLD_WR  = 4'd6;
  localparam logic [3:0] S_BUILT   = 4'd7;
  localparam logic [3:0] S_QCHK    = 4'd8;
  localparam logic [3:0] S_QSCAN   = 4'd9;
  localparam logic [3:0] S_QSTEP   = 4'd10;
  localparam logic [3:0] S_QOUT    = 4'd11;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_TAKE;
          state_d = stat_i.in_is_query ? S_QCHK : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o = CMD_LOAD;
        if (!stat_i.last_load) begin
          state_d = S_IDLE;
        end else if (stat_i.count_zero) begin
          state_d = S_BUILT;
        end else begin
          state_d = S_FIX_RD;
        end
      end
      S_FIX_RD: begin
        cmd_o   = CMD_FIX_RD;
        state_d = S_FIX_WR;
      end
      S_FIX_WR: begin
        cmd_o = CMD_FIX_WR;
        if (!stat_i.j_last) begin
          state_d = S_FIX_RD;
        end else if (stat_i.lvl_last) begin
          state_d = S_BUILT;
        end else begin
          state_d = S_BLD_RD1;
        end
      end
      S_BLD_RD1: begin
        cmd_o   = CMD_BLD_RD1;
        state_d = S_BLD_CHK;
      end
      S_BLD_CHK: begin
        // follow the midpoint only if it is a node in use
        if (stat_i.rd_in_use) begin
          cmd_o   = CMD_BLD_RD2;
          state_d = S_BLD_WR;
        end else begin
          cmd_o   = CMD_BLD_SKIP;
          state_d = (stat_i.j_last && stat_i.lvl_last) ? S_BUILT : S_BLD_RD1;
        end
      end
      S_BLD_WR: begin
        cmd_o   = CMD_BLD_WR;
        state_d = (stat_i.j_last && stat_i.lvl_last) ? S_BUILT : S_BLD_RD1;
      end
      S_BUILT: begin
        cmd_o   = CMD_SET_BUILT;
        state_d = S_IDLE;
      end
      S_QCHK: begin
        if (stat_i.q_ok) begin
          state_d = S_QSCAN;
        end else begin
          cmd_o   = CMD_Q_NONE;
          state_d = S_QOUT;
        end
      end
      S_QSCAN: begin
        if (stat_i.bit_set) begin
          cmd_o   = CMD_Q_RD;
          state_d = S_QSTEP;
        end else if (stat_i.lvl_last) begin
          cmd_o   = CMD_Q_END;
          state_d = S_QOUT;
        end else begin
          cmd_o = CMD_Q_NEXT;
        end
      end
      S_QSTEP: begin
        if (!stat_i.rd_in_use) begin
          cmd_o   = CMD_Q_NONE;
          state_d = S_QOUT;
        end else begin
          cmd_o   = CMD_Q_STEP;
          state_d = stat_i.lvl_last ? S_QOUT : S_QSCAN;
        end
      end
      S_QOUT: begin
        // hold until the output register frees up
        if (stat_i.out_free) begin
          cmd_o   = CMD_Q_PUSH;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o == CMD_TAKE) |=> (state_q == S_LOAD || state_q == S_QCHK))
    else $error("taken item not dispatched");

  a_push_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o == CMD_Q_PUSH) |=> (state_q == S_IDLE))
    else $error("push did not end the query");

  a_build_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BUILT) |-> ($past(state_q) == S_LOAD ||
      $past(state_q) == S_FIX_WR || $past(state_q) == S_BLD_CHK ||
      $past(state_q) == S_BLD_WR))
    else $error("build finished from an unexpected state");

endmodule

[hw/rtl/kth_ancestor_binary_lifting_unit.sv]
// ----------------------------------------------------------------------------
// kth_ancestor_binary_lifting_unit
// K-th ancestor lookup over a binary-lifting table held in on-chip memory.
// ----------------------------------------------------------------------------
// Items are taken one at a time; the next item is accepted as soon as the
// previous one has left the controller, even while a query result still waits
// on the output. A load with last also builds the table: it range-checks the
// level-0 entry of each node in use, then fills each of the LEVELS-1 upper
// levels node by node, and finally marks the table built. A query scans the
// bits of the distance level by level, with a registered read of the table for
// each set bit. Results are -1 (all ones) for an unbuilt table, an
// out-of-range node or distance, or a walk past the root. Writing node_count
// clears the built state; reload the last entry to rebuild.
// ----------------------------------------------------------------------------
module kth_ancestor_binary_lifting_unit import kab_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int LEVELS    = DEF_LEVELS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // node_count
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CNT_W-1:0]       cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // node_index [9:0], parent_of_node [20:10], distance [30:21], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // operation [0]
  input  logic                   s_axis_tuser,
  // last_load
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // ancestor [10:0], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  kab_cmd_e  cmd;
  kab_stat_t stat;
  logic      in_ready;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = in_ready;

  kab_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  kab_dp #(
    .MAX_NODES (MAX_NODES),
    .LEVELS    (LEVELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_op_i     (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stream-level test of the k-th ancestor binary-lifting unit. Parent entries
// are loaded as random and hand-made trees; the load marked last builds the
// table. Queries go out with random node and distance. A predictor holds its
// own lifting table and node count and queues the expected ancestor of each
// query. A checker compares every result transfer in order. Both stream sides
// idle at random; node_count is changed between phases while the unit is idle.
// ----------------------------------------------------------------------------
module testbench import kab_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_N       = DEF_MAX_NODES;
  localparam int LVLS        = DEF_LEVELS;
  localparam int CYCLE_LIMIT = 1000000;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic signed [ANC_W-1:0] node_ref_t;
  localparam node_ref_t NO_NODE = '1;

  typedef enum int {SHAPE_CHAIN, SHAPE_BUSHY, SHAPE_LADDER} tree_shape_e;

  typedef struct {
    logic                     op;
    logic [NODE_W-1:0]        node;
    logic signed [PAR_W-1:0]  parent;
    logic                     last;
    logic [DIST_W-1:0]        steps;
  } kab_item_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CNT_W-1:0]       cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Predictor state
  node_ref_t        lift_tab [MAX_N][LVLS];
  bit               tab_built;
  logic [CNT_W-1:0] node_cnt;
  node_ref_t        expected_anc_q [$];

  int  err_count   = 0;
  int  cycle_count = 0;
  int  stall_left  = 0;
  bit  src_idle_on = 1'b1;
  bit  sink_stall_on = 1'b1;

  kth_ancestor_binary_lifting_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial forever #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int active_nodes();
    return (int'(node_cnt) < MAX_N) ? int'(node_cnt) : MAX_N;
  endfunction

  function automatic bit in_use(int v, int c);
    return v >= 0 && v < c;
  endfunction

  function automatic void build_lifting(int c);
    int mid;
    for (int j = 0; j < c; j++) begin
      if (!in_use(lift_tab[j][0], c)) lift_tab[j][0] = NO_NODE;
    end
    for (int l = 1; l < LVLS; l++) begin
      for (int j = 0; j < c; j++) begin
        mid = lift_tab[j][l-1];
        if (in_use(mid, c)) lift_tab[j][l] = lift_tab[mid][l-1];
        else lift_tab[j][l] = NO_NODE;
      end
    end
    tab_built = 1'b1;
  endfunction

  function automatic node_ref_t walk_ancestor(int node, int k, int c);
    int cur;
    cur = node;
    if (!tab_built || node >= c || k >= c || (k >> LVLS) != 0) return NO_NODE;
    for (int l = 0; l < LVLS; l++) begin
      if (((k >> l) & 1) != 0) begin
        if (!in_use(cur, c)) return NO_NODE;
        cur = lift_tab[cur][l];
        if (!in_use(cur, c)) return NO_NODE;
      end
    end
    return node_ref_t'(cur);
  endfunction

  function automatic void predict_item(kab_item_t it);
    int c;
    c = active_nodes();
    if (it.op == OP_LOAD) begin
      if (int'(it.node) < c)
        lift_tab[it.node][0] = in_use(int'(it.parent), c) ? node_ref_t'(it.parent) : NO_NODE;
      if (it.last) build_lifting(c);
      else tab_built = 1'b0;
    end else begin
      expected_anc_q.push_back(walk_ancestor(int'(it.node), int'(it.steps), c));
    end
  endfunction

  // ----------------------------------------------------------------- drivers

  function automatic int build_cycles(int c);
    return 2 * c + 3 * c * (LVLS - 1) + 2 * LVLS + 16;
  endfunction

  task automatic send_item(input kab_item_t it);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[NODE_LSB +: NODE_W] = it.node;
    word[PAR_LSB +: PAR_W]   = it.parent;
    word[DIST_LSB +: DIST_W] = it.steps;
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= it.op;
    s_axis_tlast  <= it.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_item(it);
  endtask

  task automatic send_load(input int node, input int parent, input bit last);
    kab_item_t it;
    it.op     = OP_LOAD;
    it.node   = NODE_W'(node);
    it.parent = PAR_W'(parent);
    it.last   = last;
    it.steps  = DIST_W'($urandom_range(0, 1023));
    send_item(it);
  endtask

  task automatic send_query(input int node, input int hops);
    kab_item_t it;
    it.op     = OP_QUERY;
    it.node   = NODE_W'(node);
    it.parent = PAR_W'($urandom_range(0, 2047));
    it.last   = ($urandom_range(0, 3) == 0);
    it.steps  = DIST_W'(hops);
    send_item(it);
  endtask

  // Drop the stream, let every result arrive, then give a build time to finish.
  task automatic wait_block_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_anc_q.size() != 0) @(posedge clk_i);
    repeat (build_cycles(active_nodes())) @(posedge clk_i);
  endtask

  task automatic write_node_count(input int value);
    wait_block_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= CNT_W'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    node_cnt  = CNT_W'(value);
    tab_built = 1'b0;
  endtask

  // Load every node below c in random order; the final transfer builds.
  task automatic load_tree(input int c, input tree_shape_e shape, input bit noisy,
                           output int n_sent);
    int order [];
    int j, k, tmp, par;
    order = new[c];
    for (int i = 0; i < c; i++) order[i] = i;
    for (int i = c - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[k];
      order[k] = tmp;
    end
    for (int i = 0; i < c; i++) begin
      j = order[i];
      if (j == 0) par = -1;
      else if (noisy && $urandom_range(0, 29) == 0) par = $urandom_range(0, 2047);
      else if (noisy && $urandom_range(0, 39) == 0) par = -1;
      else begin
        case (shape)
          SHAPE_CHAIN:  par = j - 1;
          SHAPE_BUSHY:  par = $urandom_range(0, j - 1);
          default:      par = j - $urandom_range(1, (j < 4) ? j : 4);
        endcase
      end
      send_load(j, par, i == c - 1);
    end
    n_sent = c;
  endtask

  // ----------------------------------------------------------------- checker

  always @(posedge clk_i) begin : result_sink
    node_ref_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = node_ref_t'(m_axis_tdata[ANC_W-1:0]);
      if (expected_anc_q.size() == 0) begin
        $error("ancestor: unexpected result, expected none, actual %0d", got);
        err_count++;
      end else begin
        want = expected_anc_q.pop_front();
        if (got !== want) begin
          $error("ancestor: expected %0d, actual %0d", want, got);
          err_count++;
        end
      end
    end
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (sink_stall_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 14);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ------------------------------------------------------------------- tests

  // Reset count of one: unbuilt answers none, then a single-root tree.
  task automatic test_reset_state();
    send_query(0, 0);
    send_query(1023, 1023);
    send_load(0, -1, 1'b1);
    send_query(0, 0);
    send_query(0, 1);
  endtask

  task automatic test_special_cases();
    write_node_count(8);
    for (int j = 1; j < 6; j++) send_load(j, j - 1, 1'b0);
    send_load(0, -1, 1'b0);
    send_load(6, 8, 1'b0);        // parent not in use, stored as root
    send_load(7, -600, 1'b0);     // negative parent, stored as root
    send_load(900, 3, 1'b1);      // node out of range: no write, still builds
    send_query(5, 5);
    send_query(5, 6);             // walks past the root
    send_query(5, 0);
    send_query(6, 1);
    send_query(7, 1);
    send_query(8, 0);             // node out of range
    send_query(3, 8);             // distance out of range
    send_load(2, 1, 1'b0);        // plain load drops the built state
    send_query(5, 1);
    send_load(3, 6, 1'b1);
    send_query(3, 1);
    // Shrink the count: the stored parent 6 must be rechecked at build time.
    write_node_count(6);
    send_query(3, 1);
    send_load(0, -1, 1'b1);
    send_query(3, 1);
    send_query(4, 1);
    write_node_count(0);
    send_query(0, 0);
    send_load(0, -1, 1'b1);
    send_query(0, 0);
  endtask

  task automatic test_large_tree();
    int n;
    write_node_count(MAX_N);
    load_tree(MAX_N, SHAPE_CHAIN, 1'b0, n);
    send_query(1023, 1023);
    send_query(1023, 1022);
    send_query(1023, 512);
    send_query(1023, 0);
    send_query(512, 512);
    send_query(100, 101);
    repeat (20) send_query($urandom_range(0, 1023), $urandom_range(0, 1023));
    // Counts above the table size clamp to it.
    write_node_count(2047);
    send_query(1023, 1);
    send_load(1023, 1022, 1'b1);
    send_query(1023, 1023);
    send_query(767, 511);
    repeat (10) send_query($urandom_range(0, 1023), $urandom_range(0, 1023));
  endtask

  task automatic test_random_trees(input int budget, input bit idling);
    int sent, n, c, r, cnt, hops;
    sent = 0;
    while (sent < budget) begin
      src_idle_on   = idling && ($urandom_range(0, 3) != 0);
      sink_stall_on = idling && ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 24);
      if (r == 0) cnt = 0;
      else if (r == 1) cnt = 1;
      else if (r == 2) cnt = $urandom_range(64, 200);
      else cnt = $urandom_range(2, 40);
      write_node_count(cnt);
      c = active_nodes();
      load_tree(c, tree_shape_e'($urandom_range(0, 2)), 1'b1, n);
      sent += n;
      repeat ($urandom_range(10, 40)) begin
        r = $urandom_range(0, 15);
        if (r == 0) begin
          // Broken sequence: stray load, a query on the stale table, rebuild.
          send_load($urandom_range(0, 1023), $urandom_range(0, 2047), 1'b0);
          send_query($urandom_range(0, 1023), $urandom_range(0, 1023));
          send_load($urandom_range(0, 1023), (c > 0) ? $urandom_range(0, c - 1) : -1, 1'b1);
          sent += 3;
        end else if (r == 1) begin
          send_load($urandom_range(0, 1023), $urandom_range(0, 2047), 1'b1);
          sent++;
        end else if (r == 2 || c == 0) begin
          send_query($urandom_range(0, 1023), $urandom_range(0, 1023));
          sent++;
        end else begin
          case ($urandom_range(0, 3))
            0, 1:    hops = $urandom_range(0, c - 1);
            2:       hops = $urandom_range(0, (c < 8) ? c - 1 : 7);
            default: hops = $urandom_range(0, 1023);
          endcase
          send_query($urandom_range(0, c - 1), hops);
          sent++;
        end
      end
    end
  endtask

  initial begin : main
    tab_built = 1'b0;
    node_cnt  = CNT_W'(1);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_special_cases();
    test_large_tree();
    test_random_trees(70, 1'b1);
    // Closing stretch at full rate on both sides.
    test_random_trees(40, 1'b0);

    wait_block_idle();
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[kth_ancestor_binary_lifting_unit.f]
hw/rtl/kab_pkg.sv
hw/rtl/kab_mem.sv
hw/rtl/kab_dp.sv
hw/rtl/kab_ctrl.sv
hw/rtl/kth_ancestor_binary_lifting_unit.sv
verif/testbench.sv
